// File: sv/mseu_pkg.sv
`timescale 1ns / 1ps

package mseu_pkg;

    localparam int REG_COUNT  = 32;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int WORD_W     = 32;
    localparam int ICOUNT_W   = 30;

    localparam logic [WORD_W-1:0] TEXT_BASE_RST = 32'h0040_0000;

    // configuration register indexes
    localparam logic CFG_TEXT_BASE   = 1'b0;
    localparam logic CFG_INSTR_COUNT = 1'b1;

    // input actions
    localparam logic ACT_EXEC = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_RETIRED = 2'd0;
    localparam logic [1:0] KIND_LOAD    = 2'd1;
    localparam logic [1:0] KIND_STORE   = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTIU = 6'h0b;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_LUI   = 6'h0f;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2b;

    // R-type function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] instr_word;
        logic [WORD_W-1:0] load_data;
    } t_in_req;

    typedef struct packed {
        logic [1:0]           result_kind;
        logic [WORD_W-1:0]    mem_address;
        logic [WORD_W-1:0]    store_data;
        logic [WORD_W-1:0]    next_pc;
        logic                 halted;
        logic                 reg_written;
        logic [REG_IDX_W-1:0] reg_index;
        logic [WORD_W-1:0]    reg_value;
    } t_out_req;

endpackage

// File: sv/mseu_ram.sv
`timescale 1ns / 1ps

module mseu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: sv/mips_subset_execute_unit.sv
`timescale 1ns / 1ps

// Execute unit for a small MIPS-32 subset with its own register file and PC.
// Input channel (i_in_valid / o_in_stall / i_in_data): one request is either an
// instruction word fetched at the current PC or the data word for a pending lw.
// Output channel (o_out_valid / i_out_stall / o_out_data): exactly one result
// request per input request, in order: retired, load request, store request
// or ignored (halted or protocol error).
// Config port (i_cfg_we / i_cfg_index / i_cfg_data): text base (also loads the
// PC) and instruction count; write only while the unit is idle.
// Pipeline: an accepted request is registered in the input register along
// with the register file read; one execute pass then writes its result into
// the result register. Throughput: one request per cycle, back to back, while
// the receiver does not stall; a write from the request ahead is forwarded to
// the operand read of the request behind it.
// When the receiver stalls, the result register holds, then the input register
// holds and o_in_stall rises; no request is dropped.
// Reset (i_rst_n low, synchronous): PC = 0x00400000, running, no load pending,
// every register reads zero through per-entry valid bits, both channels empty.
// The end address (text base + 4 * count) is formed from the config registers.
module mips_subset_execute_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mseu_pkg::t_in_req   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mseu_pkg::t_out_req  o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    import mseu_pkg::*;

    // architectural state
    logic [WORD_W-1:0]    r_text_base;
    logic [ICOUNT_W-1:0]  r_icount;
    logic [WORD_W-1:0]    end_addr;
    logic [WORD_W-1:0]    r_pc,      n_pc;
    logic                 r_running, n_running;
    logic                 r_await,   n_await;
    logic [REG_IDX_W-1:0] r_target,  n_target;
    logic [REG_COUNT-1:0] r_rf_valid;

    // input stage
    logic                 r_s1_valid;
    t_in_req              r_s1;
    logic                 r_a_vld, r_b_vld;
    logic                 r_a_byp, r_b_byp;
    logic [WORD_W-1:0]    r_a_bypv, r_b_bypv;

    // result stage
    logic                 r_out_valid;
    t_out_req             r_out;

    logic                 advance, ex_go, in_acc;
    logic [REG_IDX_W-1:0] in_rs, in_rt;
    logic [WORD_W-1:0]    ram_a, ram_b, op_a, op_b;
    t_out_req             res;
    logic                 wr_req, wr_en;
    logic [REG_IDX_W-1:0] wr_idx;
    logic [WORD_W-1:0]    wr_val;

    assign advance    = !r_out_valid || !i_out_stall;
    assign ex_go      = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign in_rs = i_in_data.instr_word[25:21];
    assign in_rt = i_in_data.instr_word[20:16];

    // first address past the loaded program
    assign end_addr = r_text_base + {r_icount, 2'b00};

    mseu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_idx),
        .i_wdata   (wr_val),
        .i_re      (in_acc),
        .i_raddr_a (in_rs),
        .i_raddr_b (in_rt),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // operand select: forwarded write, else RAM if the entry was ever written
    assign op_a = r_a_byp ? r_a_bypv : (r_a_vld ? ram_a : '0);
    assign op_b = r_b_byp ? r_b_bypv : (r_b_vld ? ram_b : '0);

    // execute pass
    always_comb begin
        logic                 pre_halt;
        logic                 run_eff;
        logic [5:0]           op;
        logic [5:0]           fn;
        logic [REG_IDX_W-1:0] rt_f, rd_f;
        logic [4:0]           sh;
        logic [15:0]          imm;
        logic [WORD_W-1:0]    simm;
        logic [WORD_W-1:0]    pc4;

        op   = r_s1.instr_word[31:26];
        rt_f = r_s1.instr_word[20:16];
        rd_f = r_s1.instr_word[15:11];
        sh   = r_s1.instr_word[10:6];
        fn   = r_s1.instr_word[5:0];
        imm  = r_s1.instr_word[15:0];
        simm = {{16{imm[15]}}, imm};
        pc4  = r_pc + 32'd4;

        res       = '0;
        n_pc      = r_pc;
        n_running = r_running;
        n_await   = r_await;
        n_target  = r_target;
        wr_req    = 1'b0;
        wr_idx    = '0;
        wr_val    = '0;

        // an execute request that finds the PC at the end halts the core
        pre_halt = (r_s1.action == ACT_EXEC) && r_running && !r_await && (r_pc == end_addr);
        run_eff  = r_running && !pre_halt;

        if (!run_eff || (r_s1.action == ACT_EXEC && r_await)
                     || (r_s1.action == ACT_LOAD && !r_await)) begin
            res.result_kind = KIND_IGNORED;
            n_running       = run_eff;
        end else if (r_s1.action == ACT_LOAD) begin
            res.result_kind = KIND_RETIRED;
            n_await         = 1'b0;
            wr_req          = 1'b1;
            wr_idx          = r_target;
            wr_val          = r_s1.load_data;
            n_running       = (r_pc != end_addr);
        end else begin
            res.result_kind = KIND_RETIRED;
            n_pc            = pc4;
            unique case (op)
                OP_RTYPE: begin
                    wr_idx = rd_f;
                    unique case (fn) inside
                        FN_ADD, FN_ADDU: begin wr_req = 1'b1; wr_val = op_a + op_b; end
                        FN_SUB, FN_SUBU: begin wr_req = 1'b1; wr_val = op_a - op_b; end
                        FN_AND:  begin wr_req = 1'b1; wr_val = op_a & op_b; end
                        FN_OR:   begin wr_req = 1'b1; wr_val = op_a | op_b; end
                        FN_NOR:  begin wr_req = 1'b1; wr_val = ~(op_a | op_b); end
                        FN_SLTU: begin
                            wr_req = 1'b1;
                            wr_val = {{(WORD_W-1){1'b0}}, (op_a < op_b)};
                        end
                        FN_SLL:  begin wr_req = 1'b1; wr_val = op_b << sh; end
                        FN_SRL:  begin wr_req = 1'b1; wr_val = op_b >> sh; end
                        FN_JR:   n_pc = op_a;
                        default: ;
                    endcase
                end
                OP_J: n_pc = {pc4[31:28], r_s1.instr_word[25:0], 2'b00};
                OP_JAL: begin
                    wr_req = 1'b1;
                    wr_idx = REG_IDX_W'(REG_COUNT - 1);
                    wr_val = pc4 + 32'd4;
                    n_pc   = {pc4[31:28], r_s1.instr_word[25:0], 2'b00};
                end
                OP_ADDIU: begin wr_req = 1'b1; wr_idx = rt_f; wr_val = op_a + simm; end
                OP_ANDI: begin
                    wr_req = 1'b1; wr_idx = rt_f; wr_val = op_a & {16'h0000, imm};
                end
                OP_ORI: begin
                    wr_req = 1'b1; wr_idx = rt_f; wr_val = op_a | {16'h0000, imm};
                end
                OP_LUI: begin wr_req = 1'b1; wr_idx = rt_f; wr_val = {imm, 16'h0000}; end
                OP_SLTIU: begin
                    wr_req = 1'b1;
                    wr_idx = rt_f;
                    wr_val = {{(WORD_W-1){1'b0}}, (op_a < simm)};
                end
                OP_BEQ: begin
                    if (op_a == op_b) n_pc = pc4 + {simm[29:0], 2'b00};
                end
                OP_BNE: begin
                    if (op_a != op_b) n_pc = pc4 + {simm[29:0], 2'b00};
                end
                OP_LW: begin
                    res.result_kind = KIND_LOAD;
                    res.mem_address = op_a + simm;
                    n_await         = 1'b1;
                    n_target        = rt_f;
                end
                OP_SW: begin
                    res.result_kind = KIND_STORE;
                    res.mem_address = op_a + simm;
                    res.store_data  = op_b;
                end
                default: ;
            endcase
            // lw checks for halt only when its data comes back
            if (op != OP_LW) begin
                n_running = (n_pc != end_addr);
            end
        end

        // register zero is never written
        wr_en = ex_go && wr_req && (wr_idx != '0);

        res.next_pc = n_pc;
        res.halted  = !n_running;
        if (wr_req && (wr_idx != '0)) begin
            res.reg_written = 1'b1;
            res.reg_index   = wr_idx;
            res.reg_value   = wr_val;
        end
    end

    // config and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_base <= TEXT_BASE_RST;
            r_icount    <= '0;
            r_pc        <= TEXT_BASE_RST;
            r_running   <= 1'b1;
            r_await     <= 1'b0;
            r_target    <= '0;
            r_rf_valid  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TEXT_BASE: begin
                        r_text_base <= i_cfg_data;
                        r_pc        <= i_cfg_data;
                    end
                    CFG_INSTR_COUNT: r_icount <= i_cfg_data[ICOUNT_W-1:0];
                    default: ;
                endcase
            end else if (ex_go) begin
                r_pc      <= n_pc;
                r_running <= n_running;
                r_await   <= n_await;
                r_target  <= n_target;
            end
            if (wr_en) begin
                r_rf_valid[wr_idx] <= 1'b1;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (ex_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // payload plus forwarding of the write that retires at the same edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1     <= i_in_data;
            r_a_vld  <= r_rf_valid[in_rs];
            r_b_vld  <= r_rf_valid[in_rt];
            r_a_byp  <= wr_en && (wr_idx == in_rs);
            r_b_byp  <= wr_en && (wr_idx == in_rt);
            r_a_bypv <= wr_val;
            r_b_bypv <= wr_val;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ex_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_go) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: tb/sv/tb_mips_subset_execute_unit.sv
`timescale 1ns / 1ps

module tb_mips_subset_execute_unit;
    import mseu_pkg::*;

    localparam int MAX_WAIT    = 17;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_LEN   = 310;

    // codes the core does not decode: only the PC moves
    localparam logic [5:0] FN_UNUSED = 6'h3f;
    localparam logic [5:0] OP_UNUSED = 6'h3f;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_in_req  in_data;
    logic     out_valid;
    logic     out_stall;
    t_out_req out_data;
    logic     cfg_we;
    logic     cfg_index;
    logic [31:0] cfg_data;

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mips_subset_execute_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow core: register file, PC and load tracking, stepped once per
    // accepted input request, in acceptance order.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]    gpr [REG_COUNT];
    logic [WORD_W-1:0]    core_pc;
    logic [WORD_W-1:0]    text_base_q;
    logic [ICOUNT_W-1:0]  instr_count_q;
    bit                   core_running;
    bit                   load_pending;
    logic [REG_IDX_W-1:0] load_dest;

    t_out_req pending_results[$];   // predicted results not yet seen on the output
    int       mismatch_count = 0;
    int       rx_hold = 0;          // long receiver hold-off, counted down by the rx process
    bit       no_idle = 1'b0;       // both sides run back to back while set

    // register 0 is hard-wired: its writes vanish and are not reported
    function automatic void write_gpr(input logic [REG_IDX_W-1:0] idx,
                                      input logic [WORD_W-1:0] val,
                                      inout t_out_req res);
        if (idx != '0) begin
            gpr[idx]        = val;
            res.reg_written = 1'b1;
            res.reg_index   = idx;
            res.reg_value   = val;
        end
    endfunction

    function automatic t_out_req step_core(input t_in_req req);
        t_out_req    res;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [31:0] a, b, pc4, simm, zimm, end_pc;
        res    = '0;
        end_pc = text_base_q + {instr_count_q, 2'b00};

        // an execute request that finds the PC at the end address halts the core
        if (req.action == ACT_EXEC && core_running && !load_pending && core_pc == end_pc)
            core_running = 1'b0;

        // halted, or out-of-order protocol: nothing changes
        if (!core_running || (req.action == ACT_EXEC && load_pending) ||
            (req.action == ACT_LOAD && !load_pending)) begin
            res.result_kind = KIND_IGNORED;
            res.next_pc     = core_pc;
            res.halted      = !core_running;
            return res;
        end

        res.result_kind = KIND_RETIRED;
        if (req.action == ACT_LOAD) begin
            load_pending = 1'b0;
            write_gpr(load_dest, req.load_data, res);
        end else begin
            {op, rs, rt, rd, sh, fn} = req.instr_word;
            zimm    = {16'h0000, req.instr_word[15:0]};
            simm    = {{16{req.instr_word[15]}}, req.instr_word[15:0]};
            a       = gpr[rs];
            b       = gpr[rt];
            pc4     = core_pc + 32'd4;
            core_pc = pc4;
            case (op) inside
                OP_RTYPE: begin
                    case (fn) inside
                        FN_ADD, FN_ADDU: write_gpr(rd, a + b, res);
                        FN_SUB, FN_SUBU: write_gpr(rd, a - b, res);
                        FN_AND:  write_gpr(rd, a & b, res);
                        FN_OR:   write_gpr(rd, a | b, res);
                        FN_NOR:  write_gpr(rd, ~(a | b), res);
                        FN_SLTU: write_gpr(rd, {31'd0, a < b}, res);
                        FN_SLL:  write_gpr(rd, b << sh, res);
                        FN_SRL:  write_gpr(rd, b >> sh, res);
                        FN_JR:   core_pc = a;
                        default: ;
                    endcase
                end
                OP_J, OP_JAL: begin
                    if (op == OP_JAL)
                        write_gpr(5'd31, pc4 + 32'd4, res);
                    core_pc = {pc4[31:28], req.instr_word[25:0], 2'b00};
                end
                OP_ADDIU: write_gpr(rt, a + simm, res);
                OP_ANDI:  write_gpr(rt, a & zimm, res);
                OP_ORI:   write_gpr(rt, a | zimm, res);
                OP_LUI:   write_gpr(rt, {req.instr_word[15:0], 16'h0000}, res);
                OP_SLTIU: write_gpr(rt, {31'd0, a < simm}, res);
                OP_BEQ: begin
                    if (a == b)
                        core_pc = pc4 + (simm << 2);
                end
                OP_BNE: begin
                    if (a != b)
                        core_pc = pc4 + (simm << 2);
                end
                OP_LW: begin
                    res.result_kind = KIND_LOAD;
                    res.mem_address = a + simm;
                    load_pending    = 1'b1;
                    load_dest       = rt;
                end
                OP_SW: begin
                    res.result_kind = KIND_STORE;
                    res.mem_address = a + simm;
                    res.store_data  = b;
                end
                default: ;
            endcase
        end

        // lw checks for the end only once its data has come back
        if (res.result_kind != KIND_LOAD && core_pc == end_pc)
            core_running = 1'b0;
        res.next_pc = core_pc;
        res.halted  = !core_running;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Instruction encoders and random values
    // ------------------------------------------------------------------
    function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rd,
                                          input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] sh = 5'd0);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rt,
                                          input logic [4:0] rs, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(input logic [5:0] op, input logic [25:0] target);
        return {op, target};
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // flow_ok = 0 keeps the PC strictly sequential (no branch, jump, lw or junk)
    function automatic logic [31:0] random_instr(input bit flow_ok);
        logic [4:0]  rs, rt, rd, sh;
        logic [15:0] imm;
        logic [31:0] w;
        rs = 5'($urandom);
        rt = 5'($urandom);
        rd = 5'($urandom);
        sh = 5'($urandom);
        w  = $urandom;
        case ($urandom_range(0, 3))
            0:       imm = 16'h0000;
            1:       imm = 16'hFFFF;
            2:       imm = w[31] ? 16'h8000 : 16'h7FFF;
            default: imm = w[15:0];
        endcase
        case ($urandom_range(0, flow_ok ? 23 : 16))
            0:  return enc_r(FN_ADD,  rd, rs, rt);
            1:  return enc_r(FN_ADDU, rd, rs, rt);
            2:  return enc_r(FN_SUB,  rd, rs, rt);
            3:  return enc_r(FN_SUBU, rd, rs, rt);
            4:  return enc_r(FN_AND,  rd, rs, rt);
            5:  return enc_r(FN_OR,   rd, rs, rt);
            6:  return enc_r(FN_NOR,  rd, rs, rt);
            7:  return enc_r(FN_SLTU, rd, rs, rt);
            8:  return enc_r(FN_SLL,  rd, rs, rt, sh);
            9:  return enc_r(FN_SRL,  rd, rs, rt, sh);
            10: return enc_i(OP_ADDIU, rt, rs, imm);
            11: return enc_i(OP_ANDI,  rt, rs, imm);
            12: return enc_i(OP_ORI,   rt, rs, imm);
            13: return enc_i(OP_LUI,   rt, rs, imm);
            14: return enc_i(OP_SLTIU, rt, rs, imm);
            15: return enc_i(OP_SW,    rt, rs, imm);
            16: return enc_r(FN_UNUSED ^ {2'b00, w[19:16]}, rd, rs, rt, sh);  // 0x30..0x3f
            17: return enc_i(OP_LW,  rt, rs, imm);
            18: return enc_i(OP_BEQ, rt, rs, imm);
            19: return enc_i(OP_BNE, rt, rs, imm);
            20: return enc_j(OP_J,   w[25:0]);
            21: return enc_j(OP_JAL, w[25:0]);
            22: return enc_r(FN_JR, 5'd0, rs, 5'd0);
            default: return w;
        endcase
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic string fmt_result(input t_out_req r);
        return $sformatf("kind=%0d addr=%h sdata=%h pc=%h halted=%b wr=%b r%0d=%h",
                         r.result_kind, r.mem_address, r.store_data, r.next_pc,
                         r.halted, r.reg_written, r.reg_index, r.reg_value);
    endfunction

    // ------------------------------------------------------------------
    // Sender: called at a rising edge, returns at the edge that took the
    // request. Valid stays high into the next call when it has no gap.
    // ------------------------------------------------------------------
    task automatic send_request(input logic act, input logic [31:0] word,
                                input logic [31:0] data);
        t_in_req req;
        int      gap;
        req.action     = act;
        req.instr_word = word;
        req.load_data  = data;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(step_core(req));
    endtask

    task automatic exec_instr(input logic [31:0] word);
        send_request(ACT_EXEC, word, random_word());
    endtask

    task automatic deliver_load(input logic [31:0] data);
        send_request(ACT_LOAD, random_word(), data);
    endtask

    // mostly well-formed: a pending lw usually gets its data next
    task automatic send_random_item();
        if (load_pending) begin
            if ($urandom_range(0, 9) != 0)
                deliver_load(random_word());
            else
                exec_instr(random_instr(1'b1));
        end else if ($urandom_range(0, 24) == 0) begin
            deliver_load(random_word());
        end else begin
            exec_instr(random_instr(1'b1));
        end
    endtask

    // sender pause: every predicted result has come back, pipe drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // only while idle: the core is drained before the write
    task automatic write_config(input logic idx, input logic [31:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TEXT_BASE) begin
            text_base_q = value;
            core_pc     = value;
        end else begin
            instr_count_q = value[ICOUNT_W-1:0];
        end
        repeat (2) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver stall: a fresh wait drawn after every accepted result, plus
    // the long hold-off that the backpressure test asks for.
    // ------------------------------------------------------------------
    initial begin
        int rx_wait;
        rx_wait = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold > 0) begin
                out_stall <= 1'b1;
                rx_hold--;
            end else begin
                if (out_valid && !out_stall)
                    rx_wait = draw_wait();
                if (rx_wait > 0) begin
                    out_stall <= 1'b1;
                    rx_wait--;
                end else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // result checker: in-order compare against the oldest prediction
    always @(posedge clk) begin : check_results
        t_out_req want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t unexpected result: %s", $realtime, fmt_result(out_data));
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_data !== want) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("%0t result mismatch", $realtime);
                        $display("  expected %s", fmt_result(want));
                        $display("  actual   %s", fmt_result(out_data));
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // stray data with count 0 must not trip the end check; then open the program
    task automatic test_protocol_errors();
        write_config(CFG_INSTR_COUNT, 32'd0);
        deliver_load(random_word());
        write_config(CFG_INSTR_COUNT, 32'hFFFF_FFFF);   // upper two bits dropped
        write_config(CFG_TEXT_BASE, TEXT_BASE_RST);
    endtask

    task automatic test_alu_ops();
        exec_instr(enc_i(OP_LUI,   5'd1, 5'd0, 16'hFFFF));   // r1 = ffff0000
        exec_instr(enc_i(OP_ORI,   5'd1, 5'd1, 16'hFFFF));   // zero-extended: ffffffff
        exec_instr(enc_i(OP_ADDIU, 5'd2, 5'd0, 16'hFFFF));   // sign-extended: ffffffff
        exec_instr(enc_i(OP_ANDI,  5'd3, 5'd2, 16'h8000));   // zero-extended: 00008000
        exec_instr(enc_i(OP_SLTIU, 5'd9, 5'd3, 16'hFFFF));   // unsigned vs ffffffff
        exec_instr(enc_r(FN_ADDU, 5'd4,  5'd1, 5'd2));       // wraps
        exec_instr(enc_r(FN_ADD,  5'd5,  5'd3, 5'd3));
        exec_instr(enc_r(FN_SUBU, 5'd6,  5'd0, 5'd1));
        exec_instr(enc_r(FN_SUB,  5'd7,  5'd3, 5'd2));
        exec_instr(enc_r(FN_AND,  5'd8,  5'd1, 5'd3));
        exec_instr(enc_r(FN_OR,   5'd11, 5'd3, 5'd6));
        exec_instr(enc_r(FN_NOR,  5'd12, 5'd0, 5'd0));
        exec_instr(enc_r(FN_SLTU, 5'd13, 5'd0, 5'd1));
        exec_instr(enc_r(FN_SLL,  5'd14, 5'd0, 5'd1, 5'd31));
        exec_instr(enc_r(FN_SRL,  5'd15, 5'd0, 5'd1, 5'd31));
        exec_instr(enc_i(OP_ADDIU, 5'd0, 5'd1, 16'h0005));   // write to r0 dropped
        exec_instr(enc_r(FN_UNUSED, 5'd16, 5'd1, 5'd2));     // PC only
    endtask

    task automatic test_flow_ops();
        exec_instr(enc_i(OP_BEQ, 5'd2, 5'd1, 16'hFFFF));     // taken, back onto itself
        exec_instr(enc_i(OP_BNE, 5'd2, 5'd1, 16'h0001));     // not taken
        exec_instr(enc_i(OP_BNE, 5'd1, 5'd0, 16'h7FFF));     // taken, largest forward
        exec_instr(enc_j(OP_JAL, 26'h3FF_FFFF));             // r31 = PC+8
        exec_instr(enc_j(OP_J,   26'h000_0000));             // keeps PC+4 upper nibble
        exec_instr(enc_r(FN_JR, 5'd0, 5'd3, 5'd0));
        exec_instr(enc_j(OP_UNUSED, 26'h2AA_AAAA));          // unknown opcode
    endtask

    task automatic test_memory_ops();
        exec_instr(enc_i(OP_SW, 5'd1, 5'd3, 16'hFFFC));      // rs + sext(imm)
        exec_instr(enc_i(OP_LW, 5'd10, 5'd2, 16'h7FFC));
        exec_instr(enc_r(FN_ADDU, 5'd17, 5'd1, 5'd1));       // ignored: load pending
        deliver_load(32'hFFFF_FFFF);
    endtask

    // receiver holds off long enough that the core backs up into its input
    task automatic test_backpressure();
        wait_idle();
        no_idle = 1'b1;
        rx_hold = 48;
        repeat (24) send_random_item();
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_programs();
        logic [31:0] base, count;
        for (int p = 0; p < 4; p++) begin
            if (load_pending)
                deliver_load(random_word());
            wait_idle();
            count = 32'hFFFF_FFFF;
            case (p)
                0:       base = $urandom & 32'hFFFF_FFFC;
                1:       base = 32'h0000_0000;
                2:       base = 32'hFFFF_FFFF;   // PC+4 wraps on the first step
                default: begin
                    base  = $urandom;
                    count = $urandom | 32'h2000_0000;
                end
            endcase
            write_config(CFG_TEXT_BASE, base);
            write_config(CFG_INSTR_COUNT, count);
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (i % 60 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_random_item();
            end
            no_idle = 1'b0;
        end
    endtask

    // the core never restarts once halted, so this runs last
    task automatic test_halt();
        logic [31:0] base;
        int          n;
        if (load_pending)
            deliver_load(random_word());
        wait_idle();
        base = $urandom & 32'hFFFF_FFFC;
        n    = $urandom_range(3, 8);
        write_config(CFG_TEXT_BASE, base);
        case ($urandom_range(0, 2))
            0: begin
                // last instruction is a lw: halt decided when its data returns
                write_config(CFG_INSTR_COUNT, n);
                repeat (n - 1) exec_instr(random_instr(1'b0));
                exec_instr(enc_i(OP_LW, 5'd20, 5'd1, 16'h0000));
                exec_instr(random_instr(1'b0));
                deliver_load(random_word());
            end
            1: begin
                write_config(CFG_INSTR_COUNT, n);
                repeat (n) exec_instr(random_instr(1'b0));
            end
            default: begin
                // empty program: first execute request finds PC at the end
                write_config(CFG_INSTR_COUNT, 32'd0);
                exec_instr(random_instr(1'b1));
            end
        endcase
        repeat (6) begin
            if ($urandom_range(0, 1) == 0)
                exec_instr(random_instr(1'b1));
            else
                deliver_load(random_word());
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_TEXT_BASE;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (gpr[k])
            gpr[k] = '0;
        text_base_q   = TEXT_BASE_RST;
        instr_count_q = '0;
        core_pc       = TEXT_BASE_RST;
        core_running  = 1'b1;
        load_pending  = 1'b0;
        load_dest     = '0;

        test_protocol_errors();
        test_alu_ops();
        test_flow_ops();
        test_memory_ops();
        test_backpressure();
        test_random_programs();
        test_halt();
        wait_idle();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[mips_subset_execute_unit] OK");
        else
            $display("[mips_subset_execute_unit] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(5_000_000);
        $display("[mips_subset_execute_unit] ERROR");
        $finish;
    end

endmodule
